### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define V3AU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define V3AU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/v3au_pkg.sv
package v3au_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int FUNC_W     = 3;
  localparam int SQ_W       = 2 * WORD_BITS;
  localparam int NUM_W      = WORD_BITS + FRAC_BITS;
  localparam int IN_DATA_W  = 7 * WORD_BITS;
  localparam int OUT_DATA_W = 4 * WORD_BITS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        uword_t;
  typedef logic [SQ_W-1:0]             sq_t;
  typedef logic [NUM_W-1:0]            num_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD, FN_SUB, FN_SCALE, FN_DIV, FN_MAG, FN_NORM, FN_DOT, FN_CROSS
  } func_t;

endpackage

### hw/rtl/v3au_sqrt.sv
module v3au_sqrt (
  input  logic             clk,
  input  logic             en,
  input  v3au_pkg::sq_t    value,
  output v3au_pkg::uword_t root
);
  import v3au_pkg::*;

  localparam int STAGES = WORD_BITS;
  localparam int REM_W  = WORD_BITS + 1;
  localparam int SH_W   = WORD_BITS + 3;

  logic [REM_W-1:0] rem_q   [STAGES];
  uword_t           root_q  [STAGES];
  sq_t              bits_q  [STAGES];
  logic [REM_W-1:0] rem_in  [STAGES];
  uword_t           root_in [STAGES];
  sq_t              bits_in [STAGES];
  logic [SH_W-1:0]  rem_sh  [STAGES];
  logic [SH_W-1:0]  trial   [STAGES];
  logic             take    [STAGES];

  // one root bit per stage
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        rem_in[k]  = '0;
        root_in[k] = '0;
        bits_in[k] = value;
      end else begin
        rem_in[k]  = rem_q[k-1];
        root_in[k] = root_q[k-1];
        bits_in[k] = bits_q[k-1];
      end
      rem_sh[k] = {rem_in[k], bits_in[k][SQ_W-1 -: 2]};
      trial[k]  = {1'b0, root_in[k], 2'b01};
      take[k]   = rem_sh[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        rem_q[k]  <= take[k] ? REM_W'(rem_sh[k] - trial[k]) : rem_sh[k][REM_W-1:0];
        root_q[k] <= {root_in[k][WORD_BITS-2:0], take[k]};
        bits_q[k] <= bits_in[k] << 2;
      end
    end
  end

  assign root = root_q[STAGES-1];

endmodule

### hw/rtl/v3au_div.sv
module v3au_div (
  input  logic             clk,
  input  logic             en,
  input  v3au_pkg::num_t   num,
  input  v3au_pkg::uword_t den,
  output v3au_pkg::num_t   quo
);
  import v3au_pkg::*;

  localparam int STAGES = NUM_W;
  localparam int DEN_W  = WORD_BITS;

  logic [DEN_W-1:0] rem_q   [STAGES];
  num_t             nq_q    [STAGES];
  uword_t           den_q   [STAGES];
  logic [DEN_W-1:0] rem_in  [STAGES];
  num_t             nq_in   [STAGES];
  uword_t           den_in  [STAGES];
  logic [DEN_W:0]   rem_sh  [STAGES];
  logic             take    [STAGES];

  // restoring division, one quotient bit per stage; numerator shifts out
  // the top while quotient bits shift in at the bottom
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      if (k == 0) begin
        rem_in[k] = '0;
        nq_in[k]  = num;
        den_in[k] = den;
      end else begin
        rem_in[k] = rem_q[k-1];
        nq_in[k]  = nq_q[k-1];
        den_in[k] = den_q[k-1];
      end
      rem_sh[k] = {rem_in[k], nq_in[k][NUM_W-1]};
      take[k]   = rem_sh[k] >= {1'b0, den_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STAGES; k++) begin
        rem_q[k] <= take[k] ? DEN_W'(rem_sh[k] - {1'b0, den_in[k]})
                            : rem_sh[k][DEN_W-1:0];
        nq_q[k]  <= {nq_in[k][NUM_W-2:0], take[k]};
        den_q[k] <= den_in[k];
      end
    end
  end

  assign quo = nq_q[STAGES-1];

endmodule

### hw/rtl/vector3_arith_unit.sv
// Three-component vector unit, signed Q16.16.
// Input stream (s_*): tuser carries the operation code, tdata the vectors
// a, b and the scalar. One transaction in gives exactly one out.
// Output stream (m_*): tdata carries the result vector and scalar_out,
// tuser the saturation flag.
// Every operation takes the same path: multiply, sum, shift/saturate,
// a 32-stage square root (one root bit per stage), three parallel
// 48-stage dividers (one quotient bit per stage), then the output register.
// Throughput: one transaction per cycle while the output is not stalled.
// Results leave in order of arrival.
// Reset (rst, synchronous) clears all valid bits; nothing else is needed.
// When m_tvalid is high and m_tready low, the whole pipeline holds and
// s_tready drops; a held result stays stable until taken.
module vector3_arith_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, scalar_in
  input  logic [v3au_pkg::IN_DATA_W-1:0]     s_tdata,
  // func
  input  logic [v3au_pkg::FUNC_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // res_x, res_y, res_z, scalar_out
  output logic [v3au_pkg::OUT_DATA_W-1:0]    m_tdata,
  // overflow
  output logic [0:0]                         m_tuser
);
  import v3au_pkg::*;

  `include "assert_macros.svh"

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int SUM_W  = 2 * WORD_BITS + 2;
  localparam int SL     = WORD_BITS - 1;
  localparam int DL     = NUM_W - 1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic  ovf;
    word_t val;
  } sat_t;

  typedef struct packed {
    func_t       func;
    word_t [2:0] a;
    word_t       c;
    word_t [2:0] r;
    word_t       s;
    logic        ovf;
    uword_t      mag;
  } item_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam num_t  QPOS = num_t'(uword_t'(WMAX));
  localparam num_t  QNEG = num_t'(uword_t'(WMIN));

  function automatic sat_t sat_w(input sum_t v);
    sat_t o;
    if (v > sum_t'(WMAX)) begin
      o = '{ovf: 1'b1, val: WMAX};
    end else if (v < sum_t'(WMIN)) begin
      o = '{ovf: 1'b1, val: WMIN};
    end else begin
      o = '{ovf: 1'b0, val: word_t'(v[WORD_BITS-1:0])};
    end
    return o;
  endfunction

  function automatic sat_t sat_q(input num_t q, input logic neg);
    sat_t o;
    if (neg) begin
      if (q > QNEG) o = '{ovf: 1'b1, val: WMIN};
      else o = '{ovf: 1'b0, val: word_t'(uword_t'(~q[WORD_BITS-1:0]) + uword_t'(1))};
    end else begin
      if (q > QPOS) o = '{ovf: 1'b1, val: WMAX};
      else o = '{ovf: 1'b0, val: word_t'(q[WORD_BITS-1:0])};
    end
    return o;
  endfunction

  logic advance;
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance;

  // stage 1: operand select and products
  func_t func_in;
  word_t a_in [3];
  word_t b_in [3];
  word_t c_in;
  word_t mx   [6];
  word_t my   [6];

  logic  v1;
  func_t f1;
  word_t a1 [3];
  word_t b1 [3];
  prod_t p1 [6];

  always_comb begin
    func_in = func_t'(s_tuser);
    for (int i = 0; i < 3; i++) begin
      a_in[i] = word_t'(s_tdata[i*WORD_BITS +: WORD_BITS]);
      b_in[i] = word_t'(s_tdata[(i+3)*WORD_BITS +: WORD_BITS]);
    end
    c_in = word_t'(s_tdata[6*WORD_BITS +: WORD_BITS]);
    for (int i = 0; i < 3; i++) begin
      unique case (func_in)
        FN_SCALE: begin
          mx[i] = a_in[i];
          my[i] = c_in;
        end
        FN_MAG, FN_NORM: begin
          mx[i] = a_in[i];
          my[i] = a_in[i];
        end
        FN_CROSS: begin
          mx[i] = a_in[(i+1)%3];
          my[i] = b_in[(i+2)%3];
        end
        FN_ADD, FN_SUB, FN_DIV, FN_DOT: begin
          mx[i] = a_in[i];
          my[i] = b_in[i];
        end
      endcase
      mx[i+3] = a_in[(i+2)%3];
      my[i+3] = b_in[(i+1)%3];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1 <= func_in;
      for (int i = 0; i < 3; i++) begin
        a1[i] <= a_in[i];
        b1[i] <= b_in[i];
      end
      for (int i = 0; i < 6; i++) begin
        p1[i] <= prod_t'(mx[i]) * prod_t'(my[i]);
      end
    end
  end

  // stage 2: sums and differences
  word_t c1;
  always_ff @(posedge clk) begin
    if (advance) c1 <= c_in;
  end

  sum_t  s2_next [3];
  logic  v2;
  func_t f2;
  word_t a2 [3];
  word_t c2;
  sum_t  s2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_next[i] = '0;
    end
    unique case (f1)
      FN_ADD: begin
        for (int i = 0; i < 3; i++) s2_next[i] = sum_t'(a1[i]) + sum_t'(b1[i]);
      end
      FN_SUB: begin
        for (int i = 0; i < 3; i++) s2_next[i] = sum_t'(a1[i]) - sum_t'(b1[i]);
      end
      FN_SCALE: begin
        for (int i = 0; i < 3; i++) s2_next[i] = sum_t'(p1[i]);
      end
      FN_MAG, FN_NORM, FN_DOT: begin
        s2_next[0] = sum_t'(p1[0]) + sum_t'(p1[1]) + sum_t'(p1[2]);
      end
      FN_CROSS: begin
        for (int i = 0; i < 3; i++) s2_next[i] = sum_t'(p1[i]) - sum_t'(p1[i+3]);
      end
      FN_DIV: begin
        for (int i = 0; i < 3; i++) s2_next[i] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f2 <= f1;
      c2 <= c1;
      for (int i = 0; i < 3; i++) begin
        a2[i] <= a1[i];
        s2[i] <= s2_next[i];
      end
    end
  end

  // stage 3: floor shift and saturation
  item_t st3_next;
  item_t st3;
  sq_t   sq3;
  logic  v3;
  sat_t  sat_v [3];
  sat_t  sat_sh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_v[i]  = sat_w(s2[i]);
      sat_sh[i] = sat_w(s2[i] >>> FRAC_BITS);
    end
    st3_next      = '0;
    st3_next.func = f2;
    st3_next.c    = c2;
    for (int i = 0; i < 3; i++) st3_next.a[i] = a2[i];
    unique case (f2)
      FN_ADD, FN_SUB: begin
        for (int i = 0; i < 3; i++) st3_next.r[i] = sat_v[i].val;
        st3_next.ovf = sat_v[0].ovf | sat_v[1].ovf | sat_v[2].ovf;
      end
      FN_SCALE, FN_CROSS: begin
        for (int i = 0; i < 3; i++) st3_next.r[i] = sat_sh[i].val;
        st3_next.ovf = sat_sh[0].ovf | sat_sh[1].ovf | sat_sh[2].ovf;
      end
      FN_DOT: begin
        st3_next.s   = sat_sh[0].val;
        st3_next.ovf = sat_sh[0].ovf;
      end
      FN_DIV, FN_MAG, FN_NORM: begin
        st3_next.ovf = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st3 <= st3_next;
      sq3 <= s2[0][SQ_W-1:0];
    end
  end

  // square root and its side line
  uword_t root;
  item_t  sline [WORD_BITS];
  logic   sv    [WORD_BITS];

  v3au_sqrt u_sqrt (
    .clk   (clk),
    .en    (advance),
    .value (sq3),
    .root  (root)
  );

  // divider entry
  item_t  d_in;
  uword_t abs_a [3];
  uword_t abs_c;
  uword_t den;
  num_t   quo   [3];
  item_t  dline [NUM_W];
  logic   dv    [NUM_W];

  always_comb begin
    d_in     = sline[SL];
    d_in.mag = root;
    for (int i = 0; i < 3; i++) begin
      abs_a[i] = d_in.a[i][WORD_BITS-1] ? uword_t'(~d_in.a[i]) + uword_t'(1)
                                        : uword_t'(d_in.a[i]);
    end
    abs_c = d_in.c[WORD_BITS-1] ? uword_t'(~d_in.c) + uword_t'(1) : uword_t'(d_in.c);
    den   = (d_in.func == FN_NORM) ? root : abs_c;
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    v3au_div u_div (
      .clk (clk),
      .en  (advance),
      .num ({abs_a[g], {FRAC_BITS{1'b0}}}),
      .den (den),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sline[0] <= st3;
      for (int k = 1; k < WORD_BITS; k++) sline[k] <= sline[k-1];
      dline[0] <= d_in;
      for (int k = 1; k < NUM_W; k++) dline[k] <= dline[k-1];
    end
  end

  // final select
  item_t dl;
  sat_t  q_sat [3];
  word_t o_r   [3];
  word_t o_s;
  logic  o_ovf;

  always_comb begin
    dl    = dline[DL];
    o_s   = dl.s;
    o_ovf = dl.ovf;
    for (int i = 0; i < 3; i++) begin
      o_r[i]   = dl.r[i];
      q_sat[i] = sat_q(quo[i], dl.a[i][WORD_BITS-1] ^
                       ((dl.func == FN_DIV) & dl.c[WORD_BITS-1]));
    end
    unique case (dl.func)
      FN_DIV: begin
        if (dl.c == '0) begin
          o_ovf = 1'b1;
          for (int i = 0; i < 3; i++) begin
            if (dl.a[i] == '0) o_r[i] = '0;
            else o_r[i] = dl.a[i][WORD_BITS-1] ? WMIN : WMAX;
          end
        end else begin
          for (int i = 0; i < 3; i++) o_r[i] = q_sat[i].val;
          o_ovf = q_sat[0].ovf | q_sat[1].ovf | q_sat[2].ovf;
        end
      end
      FN_MAG: begin
        o_s   = dl.mag[WORD_BITS-1] ? WMAX : word_t'(dl.mag);
        o_ovf = dl.mag[WORD_BITS-1];
      end
      FN_NORM: begin
        if (dl.mag == '0) begin
          for (int i = 0; i < 3; i++) o_r[i] = dl.a[i];
        end else begin
          for (int i = 0; i < 3; i++) o_r[i] = q_sat[i].val;
          o_ovf = q_sat[0].ovf | q_sat[1].ovf | q_sat[2].ovf;
        end
      end
      FN_ADD, FN_SUB, FN_SCALE, FN_DOT, FN_CROSS: begin
        o_ovf = dl.ovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {o_s, o_r[2], o_r[1], o_r[0]};
      m_tuser <= o_ovf;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < WORD_BITS; k++) sv[k] <= 1'b0;
      for (int k = 0; k < NUM_W; k++) dv[k] <= 1'b0;
    end else if (advance) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      sv[0] <= v3;
      for (int k = 1; k < WORD_BITS; k++) sv[k] <= sv[k-1];
      dv[0] <= sv[SL];
      for (int k = 1; k < NUM_W; k++) dv[k] <= dv[k-1];
      m_tvalid <= dv[DL];
    end
  end

  `V3AU_ASSERT_NEXT(a_accept_enters, s_tvalid && s_tready, v1, "accepted transaction lost at entry")
  `V3AU_ASSERT_NEXT(a_mag_zero_vec, advance && dv[DL] && dl.func == FN_MAG, m_tdata[3*WORD_BITS-1:0] == '0, "magnitude result has nonzero vector")
  `V3AU_ASSERT_NEXT(a_norm_no_ovf, advance && dv[DL] && dl.func == FN_NORM, !m_tuser[0], "normalize saturated")
  `V3AU_ASSERT_IMPL(a_dot_zero_vec, dv[DL] && dl.func == FN_DOT, dl.r == '0, "dot product carries nonzero vector")

endmodule

### bench/v3au_checker.sv
module v3au_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [v3au_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [v3au_pkg::FUNC_W-1:0]     s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [v3au_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [0:0]                      m_tuser,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import v3au_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    word_t res_x;
    word_t res_y;
    word_t res_z;
    word_t scalar_out;
    logic  overflow;
  } vec_result_t;

  vec_result_t result_q[$];

  function automatic wide_t clamp_word(wide_t v, inout logic ovf);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ovf = 1'b1;
      return hi;
    end
    if (v < lo) begin
      ovf = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic wide_t fixed_div(wide_t num, wide_t den, inout logic ovf);
    wide_t hi;
    hi = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
    if (den == 0) begin
      ovf = 1'b1;
      if (num > 0) return hi;
      if (num < 0) return -hi - 1;
      return 0;
    end
    return clamp_word((num <<< FRAC_BITS) / den, ovf);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] one;
    res = 0;
    one = 64'd1 << 62;
    while (one > n) one = one >> 2;
    while (one != 0) begin
      if (n >= res + one) begin
        n = n - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic vec_result_t vector_op(func_t fn, logic [IN_DATA_W-1:0] d);
    wide_t a[3];
    wide_t b[3];
    wide_t c;
    wide_t r[3];
    wide_t s;
    wide_t mag;
    logic [63:0] sq;
    logic ovf;
    vec_result_t e;
    for (int i = 0; i < 3; i++) begin
      a[i] = word_t'(d[i*WORD_BITS +: WORD_BITS]);
      b[i] = word_t'(d[(i+3)*WORD_BITS +: WORD_BITS]);
      r[i] = 0;
    end
    c = word_t'(d[6*WORD_BITS +: WORD_BITS]);
    s = 0;
    ovf = 1'b0;
    case (fn)
      FN_ADD: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] + b[i], ovf);
      FN_SUB: for (int i = 0; i < 3; i++) r[i] = clamp_word(a[i] - b[i], ovf);
      FN_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp_word((a[i] * c) >>> FRAC_BITS, ovf);
      FN_DIV: for (int i = 0; i < 3; i++) r[i] = fixed_div(a[i], c, ovf);
      FN_MAG, FN_NORM: begin
        sq = 64'(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        mag = wide_t'(int_sqrt(sq));
        if (fn == FN_MAG) s = clamp_word(mag, ovf);
        else if (mag == 0) for (int i = 0; i < 3; i++) r[i] = a[i];
        else for (int i = 0; i < 3; i++) r[i] = fixed_div(a[i], mag, ovf);
      end
      FN_DOT: s = clamp_word((a[0]*b[0] + a[1]*b[1] + a[2]*b[2]) >>> FRAC_BITS, ovf);
      default: begin
        r[0] = clamp_word((a[1]*b[2] - a[2]*b[1]) >>> FRAC_BITS, ovf);
        r[1] = clamp_word((a[2]*b[0] - a[0]*b[2]) >>> FRAC_BITS, ovf);
        r[2] = clamp_word((a[0]*b[1] - a[1]*b[0]) >>> FRAC_BITS, ovf);
      end
    endcase
    e.res_x = r[0][WORD_BITS-1:0];
    e.res_y = r[1][WORD_BITS-1:0];
    e.res_z = r[2][WORD_BITS-1:0];
    e.scalar_out = s[WORD_BITS-1:0];
    e.overflow = ovf;
    return e;
  endfunction

  always @(posedge clk) begin
    vec_result_t e;
    vec_result_t got;
    if (rst) begin
      result_q.delete();
      errors = 0;
      pending = 0;
    end else begin
      if (s_tvalid && s_tready) result_q.push_back(vector_op(func_t'(s_tuser), s_tdata));
      if (m_tvalid && m_tready) begin
        got.res_x = m_tdata[0 +: WORD_BITS];
        got.res_y = m_tdata[WORD_BITS +: WORD_BITS];
        got.res_z = m_tdata[2*WORD_BITS +: WORD_BITS];
        got.scalar_out = m_tdata[3*WORD_BITS +: WORD_BITS];
        got.overflow = m_tuser[0];
        if (result_q.size() == 0) begin
          $error("output transaction with no expected result");
          errors++;
        end else begin
          e = result_q.pop_front();
          if (got.res_x !== e.res_x) begin
            $error("res_x: expected %h, got %h", e.res_x, got.res_x);
            errors++;
          end
          if (got.res_y !== e.res_y) begin
            $error("res_y: expected %h, got %h", e.res_y, got.res_y);
            errors++;
          end
          if (got.res_z !== e.res_z) begin
            $error("res_z: expected %h, got %h", e.res_z, got.res_z);
            errors++;
          end
          if (got.scalar_out !== e.scalar_out) begin
            $error("scalar_out: expected %h, got %h", e.scalar_out, got.scalar_out);
            errors++;
          end
          if (got.overflow !== e.overflow) begin
            $error("overflow: expected %b, got %b", e.overflow, got.overflow);
            errors++;
          end
        end
      end
      pending = result_q.size();
    end
  end
endmodule

### bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import v3au_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int NUM_RANDOM = 1800;
  localparam word_t WMAX = 32'sh7fffffff;
  localparam word_t WMIN = 32'sh80000000;
  localparam word_t ONE = 32'sh00010000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0] m_tuser;
  int errors;
  int pending;
  int cycles = 0;
  int burst_left = 0;

  always #10 clk = ~clk;

  vector3_arith_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  v3au_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  // receiver stall pattern rotates through four modes, chosen from the cycle counter
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    case ((cycles / 256) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= cycles[0];
      2: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ((cycles % 16) >= 5);
    endcase
  end

  task automatic send(func_t f, word_t ax, word_t ay, word_t az,
                      word_t bx, word_t by, word_t bz, word_t c);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 30);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= {c, bz, by, bx, az, ay, ax};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 9))
      0: return WMAX;
      1: return WMIN;
      2: return 0;
      3: return ($urandom_range(0, 1) != 0) ? ONE : -ONE;
      4, 5: return word_t'($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      6: return word_t'($urandom_range(0, 32'h3ffffff)) - 32'sh2000000;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(FN_ADD, 0, 0, 0, 0, 0, 0, 0);
    send(FN_ADD, WMAX, WMIN, ONE, ONE, -ONE, 5, 0);
    send(FN_SUB, WMIN, WMAX, 3, ONE, -ONE, 7, 0);
    send(FN_SUB, WMAX, WMIN, -1, WMIN, WMAX, -1, 0);
    send(FN_SCALE, ONE, -ONE, WMAX, 0, 0, 0, 2 * ONE);
    send(FN_SCALE, WMAX, WMIN, 3, 0, 0, 0, WMIN);
    send(FN_SCALE, -3, 3, WMAX, 0, 0, 0, WMAX);
    send(FN_DIV, ONE, -ONE, 0, 0, 0, 0, 0);
    send(FN_DIV, WMAX, WMIN, 7 * ONE, 0, 0, 0, 1);
    send(FN_DIV, WMIN, WMAX, -5 * ONE, 0, 0, 0, -1);
    send(FN_DIV, 10 * ONE, -10 * ONE, 3, 0, 0, 0, 3 * ONE);
    send(FN_MAG, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
    send(FN_MAG, WMAX, WMIN, WMIN, 0, 0, 0, 0);
    send(FN_MAG, 0, 0, 0, 0, 0, 0, 0);
    send(FN_NORM, 0, 0, 0, 0, 0, 0, 0);
    send(FN_NORM, 3 * ONE, -4 * ONE, 0, 0, 0, 0, 0);
    send(FN_NORM, 1, 0, 0, 0, 0, 0, 0);
    send(FN_NORM, WMIN, WMAX, WMIN, 0, 0, 0, 0);
    send(FN_DOT, ONE, 2 * ONE, 3 * ONE, 4 * ONE, -5 * ONE, 6 * ONE, 0);
    send(FN_DOT, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 0);
    send(FN_DOT, WMIN, WMIN, WMIN, WMAX, WMAX, WMAX, 0);
    send(FN_CROSS, ONE, 0, 0, 0, ONE, 0, 0);
    send(FN_CROSS, WMAX, WMIN, WMAX, WMIN, WMAX, WMIN, 0);
    send(FN_CROSS, -1, 1, -1, 1, -1, 1, 0);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      send(func_t'($urandom_range(0, 7)), rand_word(), rand_word(), rand_word(),
           rand_word(), rand_word(), rand_word(), rand_word());
    end
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
